>>> rtl/ita_pkg.sv
// ita_pkg: shared constants, types and helpers for the integer to ascii converter
// used by ita_digits, ita_emit, int_to_ascii_dec_hex and ita_checker
`timescale 1ns / 1ps

package ita_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    localparam logic [3:0] DEC_BASE = 4'd10;

    // decimal digits of 2^vb - 1: floor(vb * log10(2)) + 1
    function automatic int dec_digits(input int vb);
        return ((vb * 1233) >> 12) + 1;
    endfunction

    function automatic int hex_digits(input int vb);
        return (vb + 3) / 4;
    endfunction

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] r;
        if (d >= DEC_BASE) begin
            r = CH_A + {3'b000, d - DEC_BASE};
        end else begin
            r = CH_ZERO + {3'b000, d};
        end
        return r;
    endfunction

    typedef struct packed {
        logic start;
        logic neg;
        logic hex;
    } t_emit_cmd;

endpackage

>>> rtl/int_to_ascii_dec_hex.sv
// int_to_ascii_dec_hex: top level of the integer to ascii text converter
// instantiates ita_digits and ita_emit; depends on ita_pkg
`timescale 1ns / 1ps

// Usage
// Slave stream: s_tdata carries the value (VALUE_BITS bits, two's complement),
// s_tuser carries the mode: 0 signed decimal, 1 lowercase hex of the raw bits.
// Master stream: one transfer per character, most significant first, no
// leading zeros; a negative decimal value starts with '-'; m_tlast marks the
// final character. A zero value gives the single character '0'.
// Timing: one value at a time; s_tready drops after an accepted transfer and
// rises again once the final character is in the output register.
// Decimal: after the accepting cycle the shift-and-add-3 digit unit takes the
// value one bit a cycle, then hands the digits over; the emitter drops leading
// zeros one digit position at a time until the first non-zero digit, sends a
// minus first when negative, then one character per remaining digit position.
// Hex: the nibbles are handed over straight from the accepting cycle, then
// leading zeros are dropped and characters sent in the same way. The first
// character waits until every leading zero has been dropped.
// A stalled receiver holds the output register; production waits meanwhile.
// Reset (synchronous, active low) empties the output and makes s_tready high.

module int_to_ascii_dec_hex #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // value
    input  logic                              s_tuser,  // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // ch
    output logic                              m_tlast   // last
);
    import ita_pkg::*;

    localparam int DIG_W = dec_digits(VALUE_BITS) * 4;

    logic                  r_busy;
    logic                  r_neg;
    logic                  r_hex;
    logic                  n_accept;
    logic                  n_neg;
    logic [VALUE_BITS-1:0] n_value;
    logic [VALUE_BITS-1:0] n_mag;
    logic                  w_dig_done;
    logic [DIG_W-1:0]      w_digits;
    logic                  w_emit_done;
    t_emit_cmd             w_cmd;

    assign s_tready = !r_busy;
    assign n_accept = s_tvalid && !r_busy;
    assign n_value  = s_tdata[VALUE_BITS-1:0];
    assign n_neg    = !s_tuser && n_value[VALUE_BITS-1];
    // most negative value wraps to its own unsigned magnitude
    assign n_mag    = n_neg ? (~n_value + 1'b1) : n_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (n_accept) begin
            r_busy <= 1'b1;
        end else if (w_emit_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_neg <= n_neg;
            r_hex <= s_tuser;
        end
    end

    ita_digits #(
        .VALUE_BITS(VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_accept),
        .i_hex   (s_tuser),
        .i_mag   (n_mag),
        .o_done  (w_dig_done),
        .o_digits(w_digits)
    );

    assign w_cmd.start = w_dig_done;
    assign w_cmd.neg   = r_neg;
    assign w_cmd.hex   = r_hex;

    ita_emit #(
        .VALUE_BITS(VALUE_BITS)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_digits(w_digits),
        .o_done  (w_emit_done),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

>>> rtl/ita_digits.sv
// ita_digits: splits a magnitude into decimal or hex digits
// decimal uses one shift-and-add-3 step per cycle; depends on ita_pkg
`timescale 1ns / 1ps

module ita_digits #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic                                        i_hex,
    input  logic [VALUE_BITS-1:0]                       i_mag,
    output logic                                        o_done,
    output logic [ita_pkg::dec_digits(VALUE_BITS)*4-1:0] o_digits
);
    import ita_pkg::*;

    localparam int NDIG  = dec_digits(VALUE_BITS);
    localparam int DIG_W = NDIG * 4;
    localparam int HEX_W = hex_digits(VALUE_BITS) * 4;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_BITS-1:0] r_shift;
    logic [DIG_W-1:0]      r_bcd;
    logic [DIG_W-1:0]      n_adj;
    logic [DIG_W-1:0]      n_hex;

    // add 3 to every bcd digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                n_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                n_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // hex nibbles aligned to the top of the digit register
    assign n_hex = DIG_W'(HEX_W'(i_mag)) << (DIG_W - HEX_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_hex) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(VALUE_BITS);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_mag;
            r_bcd   <= i_hex ? n_hex : '0;
        end else if (r_busy) begin
            r_shift <= r_shift << 1;
            r_bcd   <= {n_adj[DIG_W-2:0], r_shift[VALUE_BITS-1]};
        end
    end

    assign o_done   = r_done;
    assign o_digits = r_bcd;

endmodule

>>> rtl/ita_emit.sv
// ita_emit: drops leading zeros and sends sign and digit characters one per transfer
// holds the output register of the master stream; depends on ita_pkg
`timescale 1ns / 1ps

module ita_emit #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  ita_pkg::t_emit_cmd                          i_cmd,
    input  logic [ita_pkg::dec_digits(VALUE_BITS)*4-1:0] i_digits,
    output logic                                        o_done,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [7:0]                                  m_tdata,  // ch
    output logic                                        m_tlast   // last
);
    import ita_pkg::*;

    localparam int NDIG   = dec_digits(VALUE_BITS);
    localparam int DIG_W  = NDIG * 4;
    localparam int NHEX   = hex_digits(VALUE_BITS);
    localparam int LEFT_W = $clog2(NDIG + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SKIP = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state            r_state;
    logic [DIG_W-1:0]  r_dig;
    logic [LEFT_W-1:0] r_left;
    logic              r_neg;
    logic              r_ovalid;
    logic [6:0]        r_och;
    logic              r_olast;
    logic              n_can_load;
    logic [3:0]        n_top;

    assign n_can_load = !r_ovalid || m_tready;
    assign n_top      = r_dig[DIG_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd.start) begin
                        r_state <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if (n_top != 4'd0 || r_left == LEFT_W'(1)) begin
                        r_state <= r_neg ? ST_SIGN : ST_EMIT;
                    end
                end
                ST_SIGN: begin
                    if (n_can_load) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (n_can_load) begin
                        r_ovalid <= 1'b1;
                        if (r_left == LEFT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd.start) begin
            r_dig  <= i_digits;
            r_left <= i_cmd.hex ? LEFT_W'(NHEX) : LEFT_W'(NDIG);
            r_neg  <= i_cmd.neg;
        end else if (r_state == ST_SKIP) begin
            if (n_top == 4'd0 && r_left != LEFT_W'(1)) begin
                r_dig  <= r_dig << 4;
                r_left <= r_left - 1'b1;
            end
        end else if (r_state == ST_SIGN) begin
            if (n_can_load) begin
                r_och   <= CH_MINUS;
                r_olast <= 1'b0;
            end
        end else if (r_state == ST_EMIT) begin
            if (n_can_load) begin
                r_och   <= digit_char(n_top);
                r_olast <= (r_left == LEFT_W'(1));
                r_dig   <= r_dig << 4;
                r_left  <= r_left - 1'b1;
            end
        end
    end

    assign o_done   = (r_state == ST_EMIT) && n_can_load && (r_left == LEFT_W'(1));
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {1'b0, r_och};
    assign m_tlast  = r_olast;

endmodule

>>> rtl/ita_checker.sv
// ita_checker: port-level assertions for int_to_ascii_dec_hex
// bound to the top level below; depends on ita_pkg
`timescale 1ns / 1ps

module ita_checker #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [7:0]                      m_tdata,
    input logic                            m_tlast
);
    import ita_pkg::*;

    // a stalled character stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // a waiting value stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && !s_tready |=> !s_tvalid || ($stable(s_tdata) && $stable(s_tuser)))
        else $error("input changed while waiting");

    // one value at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a conversion runs");

    // only digits, lowercase hex letters or minus
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata >= {1'b0, CH_ZERO} && m_tdata <= {1'b0, CH_ZERO} + 8'd9) ||
                     (m_tdata >= {1'b0, CH_A} && m_tdata <= {1'b0, CH_A} + 8'd5) ||
                     (m_tdata == {1'b0, CH_MINUS}))
        else $error("character out of range");

    // a sign is always followed by digits
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata == {1'b0, CH_MINUS} |-> !m_tlast)
        else $error("minus marked as final character");

endmodule

bind int_to_ascii_dec_hex ita_checker #(
    .VALUE_BITS(VALUE_BITS)
) u_ita_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

>>> dv/int_to_ascii_dec_hex_tb.sv
// int_to_ascii_dec_hex_tb: self-checking testbench for the integer to ascii text converter
// predicts the character stream of each accepted value; depends on ita_pkg and the rtl top
`timescale 1ns / 1ps

module int_to_ascii_dec_hex_tb;

    import ita_pkg::*;

    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam int DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
    localparam int MAX_CHARS  = 11;
    localparam int SETTLE_CYCLES = 120;
    localparam int MAX_REPORTS   = 10;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    // receiver stall patterns
    localparam int RX_FREE   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_SLOW   = 2;

    typedef struct packed {
        logic [6:0] ch;
        logic       is_last;
    } t_text_char;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;  // value
    logic              s_tuser = 1'b0;  // req_type
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;  // ch
    logic              m_tlast;  // last

    t_text_char expected_text[$];
    int         mismatch_count = 0;
    int         burst_left = 0;
    int         rx_mode = RX_FREE;
    int         rx_left = 0;
    int         rx_phase = 0;

    int_to_ascii_dec_hex #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // queue the characters the converter should emit for one value
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value, input logic mode);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] radix;
        logic [3:0]            digit;
        logic [6:0]            rev[MAX_CHARS];
        logic                  neg;
        int                    nd;
        t_text_char            c;
        neg   = (mode == MODE_DEC) && value[VALUE_BITS-1];
        mag   = neg ? (~value + 1'b1) : value;
        radix = (mode == MODE_HEX) ? 16 : 10;
        nd    = 0;
        do begin
            digit = 4'(mag % radix);
            rev[nd] = (digit > 4'd9) ? (CH_A + 7'(digit - 4'd10)) : (CH_ZERO + 7'(digit));
            nd++;
            mag = mag / radix;
        end while (mag != 0);
        if (neg) begin
            c.ch = CH_MINUS;
            c.is_last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.ch = rev[i];
            c.is_last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    // one value in, with bursts and random gaps on the sending side
    task automatic send_number(input logic [VALUE_BITS-1:0] value, input logic mode);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(value);
        s_tuser  <= mode;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        predict_text(value, mode);
    endtask

    // stop offering the last value, then wait for all characters still expected
    task automatic wait_text_drained();
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_number(32'd0, MODE_DEC);
        send_number(32'd0, MODE_HEX);
        send_number(32'd1, MODE_DEC);
        send_number(32'hffff_ffff, MODE_DEC);
        send_number(32'hffff_ffff, MODE_HEX);
        send_number(32'h7fff_ffff, MODE_DEC);
        send_number(32'h7fff_ffff, MODE_HEX);
        send_number(32'h8000_0000, MODE_DEC);  // most negative: magnitude through unsigned
        send_number(32'h8000_0000, MODE_HEX);
        send_number(32'd9, MODE_DEC);
        send_number(32'd10, MODE_DEC);
        send_number(32'd15, MODE_HEX);
        send_number(32'd16, MODE_HEX);
        send_number(32'd1000000000, MODE_DEC);
        send_number(-32'sd1000000000, MODE_DEC);
        send_number(32'hdead_beef, MODE_HEX);
        send_number(32'h0abc_def0, MODE_HEX);
        send_number(32'h1234_5678, MODE_HEX);
        send_number(32'd999999999, MODE_DEC);
        send_number(-32'sd9, MODE_DEC);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        int                    k;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(1, 31);
            2: v = $urandom_range(0, 20);
            3: v = -($urandom >> $urandom_range(1, 31));
            default: begin
                // near powers of ten, where the digit count changes
                k = $urandom_range(0, 9);
                v = 1;
                repeat (k) v = v * 10;
                v = v - $urandom_range(0, 1);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic test_drain_pause();
        repeat (4) send_number(random_value(), logic'($urandom_range(0, 1)));
        wait_text_drained();
        repeat (4) send_number(random_value(), logic'($urandom_range(0, 1)));
    endtask

    task automatic test_random();
        repeat (236) send_number(random_value(), logic'($urandom_range(0, 1)));
    endtask

    // receiver stall pattern: free running, random, or one transfer in five
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_FREE, RX_SLOW);
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        rx_phase = (rx_phase + 1) % 5;
        case (rx_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
            default:   m_tready <= (rx_phase == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_text.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected transfer: ch=%h last=%b", m_tdata, m_tlast);
            end else begin
                want = expected_text.pop_front();
                if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.is_last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected ch=%h last=%b, got ch=%h last=%b",
                                 {1'b0, want.ch}, want.is_last, m_tdata, m_tlast);
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_pause();
        test_random();
        wait_text_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_text.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
